@@ rtl/odo_pkg.sv @@
// Package for the encoder/IMU odometry block: shared types, register codes,
// back-end states and the CORDIC arctangent table. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package odo_pkg;

    localparam int ANGLE_BITS_DEF      = 16;
    localparam int TRIG_ITERATIONS_DEF = 16;
    localparam int TABLE_LEN           = 24;

    // CORDIC gain 0.6072529350 in Q2.30
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

    // Configuration register indexes
    localparam logic [1:0] REG_DIST_PER_COUNT = 2'd0;
    localparam logic [1:0] REG_OFFSET_X       = 2'd1;
    localparam logic [1:0] REG_OFFSET_Y       = 2'd2;

    // Item commands
    localparam logic CMD_SAMPLE   = 1'b0;
    localparam logic CMD_SET_POSE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCALE,
        ST_ROT,
        ST_MUL,
        ST_SUM,
        ST_ACC,
        ST_OUT
    } state_t;

    // Classified item handed from the front end to the back end
    typedef struct packed {
        logic               cmd;
        logic signed [31:0] dx_count;
        logic signed [31:0] dy_count;
        logic [15:0]        heading;
        logic signed [31:0] new_x;
        logic signed [31:0] new_y;
    } q_item_t;

    typedef struct packed {
        logic [15:0]        dist_per_count;
        logic signed [31:0] offset_x;
        logic signed [31:0] offset_y;
    } cfg_t;

    // Arctangent of 2^-i in 2^-32 turns
    function automatic logic [31:0] atan_turns(input logic [4:0] idx);
        logic [31:0] r;
        unique case (idx)
            5'd0:    r = 32'h20000000;
            5'd1:    r = 32'h12E4051E;
            5'd2:    r = 32'h09FB385B;
            5'd3:    r = 32'h051111D4;
            5'd4:    r = 32'h028B0D43;
            5'd5:    r = 32'h0145D7E1;
            5'd6:    r = 32'h00A2F61E;
            5'd7:    r = 32'h00517C55;
            5'd8:    r = 32'h0028BE53;
            5'd9:    r = 32'h00145F2F;
            5'd10:   r = 32'h000A2F98;
            5'd11:   r = 32'h000517CC;
            5'd12:   r = 32'h00028BE6;
            5'd13:   r = 32'h000145F3;
            5'd14:   r = 32'h0000A2FA;
            5'd15:   r = 32'h0000517D;
            5'd16:   r = 32'h000028BE;
            5'd17:   r = 32'h0000145F;
            5'd18:   r = 32'h00000A30;
            5'd19:   r = 32'h00000518;
            5'd20:   r = 32'h0000028C;
            5'd21:   r = 32'h00000146;
            5'd22:   r = 32'h000000A3;
            5'd23:   r = 32'h00000051;
            default: r = 32'h00000000;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

@@ rtl/odo_front.sv @@
// Front end of the odometry block: accepts items, forms count deltas against
// the stored reference and queues them for the back end. Uses odo_pkg.
`timescale 1ns / 1ps
`default_nettype none
module odo_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire logic            in_cmd,
    input  wire logic [31:0]     in_x_count,
    input  wire logic [31:0]     in_y_count,
    input  wire logic [15:0]     in_heading,
    input  wire logic [31:0]     in_new_x,
    input  wire logic [31:0]     in_new_y,
    output logic                 q_valid,
    output odo_pkg::q_item_t     q_item,
    input  wire logic            q_pop
);

    odo_pkg::q_item_t q_reg [2];
    logic [31:0]      ref_x_reg;
    logic [31:0]      ref_y_reg;
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic             push;
    odo_pkg::q_item_t entry;

    assign in_ready = (count_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = q_reg[rd_ptr_reg];

    // Classify: deltas wrap modulo 2^32
    always_comb
    begin
        entry.cmd      = in_cmd;
        entry.dx_count = in_x_count - ref_x_reg;
        entry.dy_count = in_y_count - ref_y_reg;
        entry.heading  = in_heading;
        entry.new_x    = in_new_x;
        entry.new_y    = in_new_y;
    end

    always_comb
    begin
        count_next = count_reg;
        if (push && !q_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!push && q_pop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    // Advance the reference and queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_x_reg  <= '0;
            ref_y_reg  <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                ref_x_reg  <= in_x_count;
                ref_y_reg  <= in_y_count;
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= entry;
        end
    end

endmodule
`default_nettype wire

@@ rtl/odo_back.sv @@
// Back end of the odometry block: scales deltas, runs an iterative CORDIC,
// rotates, accumulates with saturation and holds the result. Uses odo_pkg.
`timescale 1ns / 1ps
`default_nettype none
module odo_back #(
    parameter int ANGLE_BITS      = odo_pkg::ANGLE_BITS_DEF,
    parameter int TRIG_ITERATIONS = odo_pkg::TRIG_ITERATIONS_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire odo_pkg::cfg_t    cfg,
    input  wire logic             q_valid,
    input  wire odo_pkg::q_item_t q_item,
    output logic                  q_pop,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [31:0]           out_pos_x,
    output logic [31:0]           out_pos_y,
    output logic [15:0]           out_heading,
    output logic                  out_saturated
);

    localparam int IT_W = (TRIG_ITERATIONS > 1) ? $clog2(TRIG_ITERATIONS) : 1;
    localparam logic [IT_W-1:0] IT_LAST = IT_W'(TRIG_ITERATIONS - 1);
    localparam logic [31:0] ANG_MASK = ~((32'd1 << (32 - ANGLE_BITS)) - 32'd1);

    odo_pkg::state_t   state_reg;
    odo_pkg::state_t   state_next;
    odo_pkg::q_item_t  item_reg;
    logic signed [47:0] dx_reg;
    logic signed [47:0] dy_reg;
    logic signed [33:0] cx_reg;
    logic signed [33:0] cy_reg;
    logic signed [33:0] cz_reg;
    logic               flip_reg;
    logic [IT_W-1:0]    it_reg;
    logic [1:0]         k_reg;
    logic signed [65:0] t_reg;
    logic signed [50:0] u_reg;
    logic signed [52:0] rx_reg;
    logic signed [52:0] ry_reg;
    logic signed [31:0] acc_x_reg;
    logic signed [31:0] acc_y_reg;
    logic               sat_reg;
    logic               out_load;

    // Starting angle, folded into the right half-plane
    logic [31:0]        ang0;
    logic [31:0]        ang1;
    logic               flip0;
    logic signed [33:0] xs;
    logic signed [33:0] ys;
    logic signed [33:0] at;
    logic signed [33:0] cs;
    logic signed [33:0] sn;
    logic signed [47:0] dsel;
    logic signed [33:0] csel;
    logic signed [31:0] hi;
    logic signed [16:0] lo;
    logic signed [65:0] t_mul;
    logic signed [50:0] u_mul;
    logic signed [81:0] full;
    logic signed [51:0] prod;
    logic signed [53:0] sum_x;
    logic signed [53:0] sum_y;
    logic               clip_x;
    logic               clip_y;
    logic signed [32:0] rep_x;
    logic signed [32:0] rep_y;

    always_comb
    begin
        ang0  = {item_reg.heading, 16'h0000} & ANG_MASK;
        ang1  = ang0 + 32'h4000_0000;
        flip0 = ang1[31];
        xs    = cx_reg >>> it_reg;
        ys    = cy_reg >>> it_reg;
        at    = $signed({2'b00, odo_pkg::atan_turns(5'(it_reg))});
        cs    = flip_reg ? -cx_reg : cx_reg;
        sn    = flip_reg ? -cy_reg : cy_reg;
        dsel  = k_reg[0] ? dy_reg : dx_reg;
        csel  = (k_reg == 2'd0 || k_reg == 2'd3) ? cs : sn;
        hi    = dsel[47:16];
        lo    = $signed({1'b0, dsel[15:0]});
        t_mul = hi * csel;
        u_mul = lo * csel;
        full  = (82'(t_reg) <<< 16) + 82'(u_reg);
        prod  = full[81:30];
        sum_x = 54'(acc_x_reg) + 54'(rx_reg);
        sum_y = 54'(acc_y_reg) + 54'(ry_reg);
        clip_x = (sum_x[53:31] != {23{sum_x[53]}});
        clip_y = (sum_y[53:31] != {23{sum_y[53]}});
        rep_x = 33'(acc_x_reg) + 33'(cfg.offset_x);
        rep_y = 33'(acc_y_reg) + 33'(cfg.offset_y);
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            odo_pkg::ST_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = (q_item.cmd == odo_pkg::CMD_SET_POSE) ?
                                 odo_pkg::ST_ACC : odo_pkg::ST_SCALE;
                end
            end
            odo_pkg::ST_SCALE: state_next = odo_pkg::ST_ROT;
            odo_pkg::ST_ROT:
            begin
                if (it_reg == IT_LAST)
                begin
                    state_next = odo_pkg::ST_MUL;
                end
            end
            odo_pkg::ST_MUL: state_next = odo_pkg::ST_SUM;
            odo_pkg::ST_SUM:
            begin
                state_next = (k_reg == 2'd3) ? odo_pkg::ST_ACC : odo_pkg::ST_MUL;
            end
            odo_pkg::ST_ACC: state_next = odo_pkg::ST_OUT;
            odo_pkg::ST_OUT:
            begin
                if (out_load)
                begin
                    state_next = odo_pkg::ST_IDLE;
                end
            end
            default: state_next = odo_pkg::ST_IDLE;
        endcase
    end

    // State outputs
    always_comb
    begin
        q_pop    = (state_reg == odo_pkg::ST_IDLE) && q_valid;
        out_load = (state_reg == odo_pkg::ST_OUT) && (!out_valid || out_ready);
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= odo_pkg::ST_IDLE;
            out_valid <= 1'b0;
            acc_x_reg <= '0;
            acc_y_reg <= '0;
            it_reg    <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid <= 1'b0;
            end
            if (state_reg == odo_pkg::ST_SCALE)
            begin
                it_reg <= '0;
                k_reg  <= '0;
            end
            if (state_reg == odo_pkg::ST_ROT && it_reg != IT_LAST)
            begin
                it_reg <= it_reg + 1'b1;
            end
            if (state_reg == odo_pkg::ST_SUM)
            begin
                k_reg <= k_reg + 2'd1;
            end
            // Load pose or accumulate with clipping
            if (state_reg == odo_pkg::ST_ACC)
            begin
                if (item_reg.cmd == odo_pkg::CMD_SET_POSE)
                begin
                    acc_x_reg <= item_reg.new_x;
                    acc_y_reg <= item_reg.new_y;
                end
                else
                begin
                    acc_x_reg <= clip_x ? (sum_x[53] ? 32'sh8000_0000 : 32'sh7FFF_FFFF)
                                        : sum_x[31:0];
                    acc_y_reg <= clip_y ? (sum_y[53] ? 32'sh8000_0000 : 32'sh7FFF_FFFF)
                                        : sum_y[31:0];
                end
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            item_reg <= q_item;
        end
        unique case (state_reg)
            odo_pkg::ST_SCALE:
            begin
                dx_reg   <= 48'(item_reg.dx_count) * 48'($signed({1'b0, cfg.dist_per_count}));
                dy_reg   <= 48'(item_reg.dy_count) * 48'($signed({1'b0, cfg.dist_per_count}));
                cx_reg   <= odo_pkg::CORDIC_GAIN;
                cy_reg   <= '0;
                flip_reg <= flip0;
                cz_reg   <= $signed(34'(signed'(flip0 ? ang0 + 32'h8000_0000 : ang0)));
            end
            odo_pkg::ST_ROT:
            begin
                if (!cz_reg[33])
                begin
                    cx_reg <= cx_reg - ys;
                    cy_reg <= cy_reg + xs;
                    cz_reg <= cz_reg - at;
                end
                else
                begin
                    cx_reg <= cx_reg + ys;
                    cy_reg <= cy_reg - xs;
                    cz_reg <= cz_reg + at;
                end
            end
            odo_pkg::ST_MUL:
            begin
                t_reg <= t_mul;
                u_reg <= u_mul;
            end
            odo_pkg::ST_SUM:
            begin
                case (k_reg)
                    2'd0:    rx_reg <= 53'(prod);
                    2'd1:    rx_reg <= rx_reg - 53'(prod);
                    2'd2:    ry_reg <= 53'(prod);
                    default: ry_reg <= ry_reg + 53'(prod);
                endcase
            end
            odo_pkg::ST_ACC:
            begin
                sat_reg <= (item_reg.cmd == odo_pkg::CMD_SAMPLE) && (clip_x || clip_y);
            end
            default:
            begin
            end
        endcase
        // Hold the result until taken
        if (out_load)
        begin
            out_pos_x     <= (rep_x[32] != rep_x[31]) ?
                             (rep_x[32] ? 32'h8000_0000 : 32'h7FFF_FFFF) : rep_x[31:0];
            out_pos_y     <= (rep_y[32] != rep_y[31]) ?
                             (rep_y[32] ? 32'h8000_0000 : 32'h7FFF_FFFF) : rep_y[31:0];
            out_heading   <= item_reg.heading;
            out_saturated <= sat_reg;
        end
    end

endmodule
`default_nettype wire

@@ rtl/encoder_imu_odometry_top.sv @@
// Encoder/IMU dead-reckoning odometry: a sample item is scaled, rotated by an iterative
// CORDIC loop and the shared rotation multiplier (four products) and accumulated; a
// set-pose item loads the position directly. The back end works one item at a time
// and holds while a result waits.
// A two-entry queue lets the front end take items while the back end works.
// Reset (rst_n, async, active low) clears position, reference counts
// and offsets, and sets distance_per_count to 1.
`timescale 1ns / 1ps
`default_nettype none
module encoder_imu_odometry_top #(
    parameter int ANGLE_BITS      = odo_pkg::ANGLE_BITS_DEF,
    parameter int TRIG_ITERATIONS = odo_pkg::TRIG_ITERATIONS_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // x_count, y_count, heading_angle, new_x, new_y
    input  wire logic [143:0] s_axis_tdata,
    // command
    input  wire logic         s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // pos_x, pos_y, heading_out, saturated, zero fill
    output logic [87:0]       m_axis_tdata,
    input  wire logic         cfg_we,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [31:0]  cfg_wdata
);

    odo_pkg::cfg_t    cfg_reg;
    odo_pkg::q_item_t q_item;
    logic             q_valid;
    logic             q_pop;
    logic [31:0]      pos_x;
    logic [31:0]      pos_y;
    logic [15:0]      heading_out;
    logic             saturated;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dist_per_count <= 16'd1;
            cfg_reg.offset_x       <= '0;
            cfg_reg.offset_y       <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                odo_pkg::REG_DIST_PER_COUNT: cfg_reg.dist_per_count <= cfg_wdata[15:0];
                odo_pkg::REG_OFFSET_X:       cfg_reg.offset_x       <= cfg_wdata;
                odo_pkg::REG_OFFSET_Y:       cfg_reg.offset_y       <= cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

    odo_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_cmd     (s_axis_tuser),
        .in_x_count (s_axis_tdata[31:0]),
        .in_y_count (s_axis_tdata[63:32]),
        .in_heading (s_axis_tdata[79:64]),
        .in_new_x   (s_axis_tdata[111:80]),
        .in_new_y   (s_axis_tdata[143:112]),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop)
    );

    odo_back #(
        .ANGLE_BITS      (ANGLE_BITS),
        .TRIG_ITERATIONS (TRIG_ITERATIONS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .out_pos_x     (pos_x),
        .out_pos_y     (pos_y),
        .out_heading   (heading_out),
        .out_saturated (saturated)
    );

    assign m_axis_tdata = {7'd0, saturated, heading_out, pos_y, pos_x};

endmodule
`default_nettype wire

@@ sim/encoder_imu_odometry_top_tb.sv @@
// Testbench for the encoder/IMU odometry block: drives sample and set-pose
// items, predicts position and heading with a bit-exact CORDIC model.
// Depends on rtl/odo_pkg.sv and rtl/encoder_imu_odometry_top.sv.
`timescale 1ns / 1ps
`default_nettype none
module encoder_imu_odometry_top_tb;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 100;

    // fields from the lowest bit up: pos_x, pos_y, heading, sat
    typedef struct packed {
        logic        sat;
        logic [15:0] heading;
        logic [31:0] pos_y;
        logic [31:0] pos_x;
    } pose_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [143:0] s_axis_tdata;
    logic         s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [87:0]  m_axis_tdata;
    logic         cfg_we;
    logic [1:0]   cfg_index;
    logic [31:0]  cfg_wdata;

    // predictor state and configuration
    logic [15:0]        dpc;
    logic signed [31:0] off_x, off_y;
    logic [31:0]        ref_xc, ref_yc;
    logic signed [63:0] pos_acc_x, pos_acc_y;
    logic [15:0]        head_last;

    pose_t expected_poses[$];
    int    errors;
    int    idle_cycles;
    int    send_idle_pct, recv_idle_pct;

    encoder_imu_odometry_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic logic signed [63:0] floor_shift(logic signed [63:0] v, int s);
        return v >>> s;
    endfunction

    function automatic logic signed [63:0] clip32(logic signed [63:0] v, ref logic hit);
        if (v > 64'sd2147483647)
        begin
            hit = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648)
        begin
            hit = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    // floor(d * c / 2^30), exact with 96-bit product
    function automatic logic signed [63:0] mul_q30(logic signed [63:0] d,
                                                   logic signed [63:0] c);
        logic signed [95:0] p;
        p = 96'(d) * 96'(c);
        p = p >>> 30;
        return p[63:0];
    endfunction

    // CORDIC rotation giving cos and sin of the heading in Q2.30
    task automatic heading_trig(input logic [15:0] hd,
                                output logic signed [63:0] cs,
                                output logic signed [63:0] sn);
        logic [31:0]        a;
        logic               flip;
        logic signed [63:0] x, y, z, xs, ys;
        a = {hd, 16'h0};
        a &= ~((32'd1 << (32 - odo_pkg::ANGLE_BITS_DEF)) - 32'd1);
        flip = a[31] ^ a[30];
        if (flip)
            a += 32'h80000000;
        x = 64'(odo_pkg::CORDIC_GAIN);
        y = 0;
        z = 64'(signed'(a));
        for (int i = 0; i < odo_pkg::TRIG_ITERATIONS_DEF && i < odo_pkg::TABLE_LEN; i++)
        begin
            xs = floor_shift(x, i);
            ys = floor_shift(y, i);
            if (z >= 0)
            begin
                x -= ys;
                y += xs;
                z -= 64'(odo_pkg::atan_turns(5'(i)));
            end
            else
            begin
                x += ys;
                y -= xs;
                z += 64'(odo_pkg::atan_turns(5'(i)));
            end
        end
        cs = flip ? -x : x;
        sn = flip ? -y : y;
    endtask

    // advance the pose model by one item and queue its result
    task automatic predict_pose(input logic cmd, input logic [31:0] xc, input logic [31:0] yc,
                                input logic [15:0] hd, input logic [31:0] nx,
                                input logic [31:0] ny);
        logic               sat, dummy;
        logic signed [63:0] dx, dy, cs, sn, rx, ry, px, py;
        logic [31:0]        dxc, dyc;
        pose_t              r;
        sat = 1'b0;
        dummy = 1'b0;
        if (cmd == odo_pkg::CMD_SET_POSE)
        begin
            pos_acc_x = 64'(signed'(nx));
            pos_acc_y = 64'(signed'(ny));
        end
        else
        begin
            dxc = xc - ref_xc;
            dyc = yc - ref_yc;
            dx = 64'(signed'(dxc)) * 64'(dpc);
            dy = 64'(signed'(dyc)) * 64'(dpc);
            heading_trig(hd, cs, sn);
            rx = mul_q30(dx, cs) - mul_q30(dy, sn);
            ry = mul_q30(dx, sn) + mul_q30(dy, cs);
            pos_acc_x = clip32(pos_acc_x + rx, sat);
            pos_acc_y = clip32(pos_acc_y + ry, sat);
        end
        ref_xc = xc;
        ref_yc = yc;
        head_last = hd;
        px = clip32(pos_acc_x + 64'(off_x), dummy);
        py = clip32(pos_acc_y + 64'(off_y), dummy);
        r.pos_x = px[31:0];
        r.pos_y = py[31:0];
        r.heading = head_last;
        r.sat = sat;
        expected_poses.push_back(r);
    endtask

    // send one item, holding it until accepted; the caller drops valid when done
    task automatic send_item(input logic cmd, input logic [31:0] xc, input logic [31:0] yc,
                             input logic [15:0] hd, input logic [31:0] nx,
                             input logic [31:0] ny);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {ny, nx, hd, yc, xc};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_pose(cmd, xc, yc, hd, nx, ny);
        @(negedge clk);
    endtask

    // wait for the block to drain, then write one register
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        s_axis_tvalid <= 1'b0;
        while (expected_poses.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            odo_pkg::REG_DIST_PER_COUNT: dpc = val[15:0];
            odo_pkg::REG_OFFSET_X:       off_x = val;
            odo_pkg::REG_OFFSET_Y:       off_y = val;
            default:                     ;
        endcase
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(5))
            0:       return 32'h7FFFFFFF;
            1:       return 32'h80000000;
            2:       return $urandom;
            default: return 32'($signed($urandom_range(4000)) - 2000);
        endcase
    endfunction

    task automatic test_directed();
        logic [31:0] xc, yc;
        // sample at zero delta, then each quadrant and the cardinal angles
        send_item(odo_pkg::CMD_SAMPLE, 0, 0, 16'h0000, 0, 0);
        xc = 0;
        yc = 0;
        for (int i = 0; i < 8; i++)
        begin
            xc += 1000;
            yc -= 300;
            send_item(odo_pkg::CMD_SAMPLE, xc, yc, 16'(i * 16'h2000), 32'hFFFFFFFF, 0);
        end
        send_item(odo_pkg::CMD_SAMPLE, xc, yc, 16'hFFFF, 0, 0);
        // set pose near both extremes of the range
        send_item(odo_pkg::CMD_SET_POSE, 32'h7FFFFFFF, 32'h80000000, 16'h4000, 32'h7FFFFFF0,
                  32'h80000010);
        // wrapping deltas push accumulation into both limits
        send_item(odo_pkg::CMD_SAMPLE, 32'h80000000, 32'h7FFFFFFF, 16'h0000, 0, 0);
        send_item(odo_pkg::CMD_SAMPLE, 32'h00000000, 32'h00000000, 16'h8000, 0, 0);
        send_item(odo_pkg::CMD_SET_POSE, 0, 0, 16'h0000, 32'h80000000, 32'h7FFFFFFF);
        send_item(odo_pkg::CMD_SAMPLE, 32'h7FFFFFFF, 32'h80000001, 16'hC000, 0, 0);
        write_reg(odo_pkg::REG_DIST_PER_COUNT, 32'd65535);
        send_item(odo_pkg::CMD_SET_POSE, 0, 0, 0, 0, 0);
        send_item(odo_pkg::CMD_SAMPLE, 32'h80000000, 32'h80000000, 16'h2000, 0, 0);
        // zero scale gives no motion
        write_reg(odo_pkg::REG_DIST_PER_COUNT, 32'd0);
        send_item(odo_pkg::CMD_SAMPLE, 32'h12345678, 32'h9ABCDEF0, 16'h1234, 0, 0);
        // offsets at the extremes clip the report only
        write_reg(odo_pkg::REG_OFFSET_X, 32'h7FFFFFFF);
        write_reg(odo_pkg::REG_OFFSET_Y, 32'h80000000);
        write_reg(2'd3, 32'hFFFFFFFF);
        send_item(odo_pkg::CMD_SET_POSE, 0, 0, 16'h1, 32'h40000000, 32'hC0000000);
        send_item(odo_pkg::CMD_SAMPLE, 0, 0, 16'h2, 0, 0);
    endtask

    task automatic test_random(input int n);
        logic [31:0] xc, yc;
        logic [15:0] hd;
        xc = $urandom;
        yc = $urandom;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(99) < 8)
                send_item(odo_pkg::CMD_SET_POSE, rand_word(), rand_word(), 16'($urandom),
                          rand_word(), rand_word());
            else
            begin
                if ($urandom_range(9) == 0)
                begin
                    xc = $urandom;
                    yc = $urandom;
                end
                else
                begin
                    xc += 32'($signed($urandom_range(20000)) - 10000);
                    yc += 32'($signed($urandom_range(20000)) - 10000);
                end
                hd = 16'($urandom);
                send_item(odo_pkg::CMD_SAMPLE, xc, yc, hd, $urandom, $urandom);
            end
        end
    endtask

    task automatic test_settings();
        send_idle_pct = 14;
        recv_idle_pct = 51;
        write_reg(odo_pkg::REG_DIST_PER_COUNT, 32'd1);
        write_reg(odo_pkg::REG_OFFSET_X, 32'd0);
        write_reg(odo_pkg::REG_OFFSET_Y, 32'd0);
        test_random(400);
        send_idle_pct = 51;
        recv_idle_pct = 14;
        write_reg(odo_pkg::REG_DIST_PER_COUNT, 32'(16'($urandom_range(65535, 1))));
        write_reg(odo_pkg::REG_OFFSET_X, $urandom);
        write_reg(odo_pkg::REG_OFFSET_Y, $urandom);
        test_random(400);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(odo_pkg::REG_DIST_PER_COUNT, 32'd65535);
        write_reg(odo_pkg::REG_OFFSET_X, 32'h80000000);
        write_reg(odo_pkg::REG_OFFSET_Y, 32'h7FFFFFFF);
        test_random(400);
    endtask

    // receiver stall pattern
    always @(negedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // check each result against the oldest expected pose
    always @(posedge clk)
    begin
        pose_t want, got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata[80:0];
            if (expected_poses.size() == 0)
            begin
                $error("unexpected result %h", m_axis_tdata);
                errors++;
            end
            else
            begin
                want = expected_poses.pop_front();
                if (got.pos_x !== want.pos_x)
                begin
                    $error("pos_x expected %h got %h", want.pos_x, got.pos_x);
                    errors++;
                end
                if (got.pos_y !== want.pos_y)
                begin
                    $error("pos_y expected %h got %h", want.pos_y, got.pos_y);
                    errors++;
                end
                if (got.heading !== want.heading)
                begin
                    $error("heading_out expected %h got %h", want.heading, got.heading);
                    errors++;
                end
                if (got.sat !== want.sat)
                begin
                    $error("saturated expected %b got %b", want.sat, got.sat);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles with neither an accepted item nor a taken result
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        errors        = 0;
        idle_cycles   = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        m_axis_tready = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_wdata     = '0;
        dpc           = 16'd1;
        off_x         = 0;
        off_y         = 0;
        ref_xc        = 0;
        ref_yc        = 0;
        pos_acc_x     = 0;
        pos_acc_y     = 0;
        head_last     = 0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        test_settings();
        s_axis_tvalid <= 1'b0;
        while (expected_poses.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
`default_nettype wire
